// ===== hw/rtl/constrained_pair_map_table_unit_defines.svh =====
// Assertion macros for the constrained pair map table unit.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef CONSTRAINED_PAIR_MAP_TABLE_UNIT_DEFINES_SVH
`define CONSTRAINED_PAIR_MAP_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CPMT_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("cpmt: implication check failed");
// next-cycle implication
`define CPMT_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("cpmt: next-cycle check failed");
`else
`define CPMT_ASSERT_IMP(lbl, clk, rstn, pre, post)
`define CPMT_ASSERT_NXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== hw/rtl/cpmt_pkg.sv =====
// Package for the constrained pair map table unit: field widths, codes, types.
// No dependencies; imported by cpmt_pair_ram, the top level, checker and tb.
package cpmt_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned COUNT_W      = 7;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_CHECK  = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_CONFLICT = 3'd2,
    ST_FULL     = 3'd3,
    ST_FOUND    = 3'd4,
    ST_MISSING  = 3'd5,
    ST_CLEAN    = 3'd6,
    ST_DONE     = 3'd7
  } status_e;

  typedef enum logic {
    MODE_ONE_TO_ONE  = 1'b0,
    MODE_MANY_TO_ONE = 1'b1
  } map_mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } pair_t;

endpackage

// ===== hw/rtl/constrained_pair_map_table_unit.sv =====
// Top level of the constrained pair map table unit: sequencer, scan and result register.
// Depends on cpmt_pkg, cpmt_pair_ram and constrained_pair_map_table_unit_defines.svh.
//
// Usage
//   Input channel (in_valid_i/in_ready_o) carries one transaction per operation:
//   opcode, key, value, entry index and fallback. Output channel
//   (out_valid_o/out_ready_i) returns exactly one result per transaction:
//   status, key, value and the entry count after the operation.
//   map_mode is written through cfg_we_i/cfg_wdata_i while the unit is idle;
//   the user keeps to this, as the block itself does not enforce it.
//   - add, lookup, check: scan of the pair RAM at one entry per cycle,
//     up to the deciding pair on a hit, over all stored pairs otherwise.
//   - read entry: a single RAM read; clear, bad index and unused opcodes: no scan.
//   The RAM read latency and the one-entry-per-cycle read port set the rate;
//   one operation is in flight at a time.
//   Reset empties the table (count to zero), selects one-to-one mode and
//   drops any pending result; RAM contents are left as they are, since only
//   entries below the count are ever read.
//   A stalled receiver holds the result in the output register; the next
//   transaction is still accepted and runs, then waits to deliver its own.
`include "constrained_pair_map_table_unit_defines.svh"

module constrained_pair_map_table_unit import cpmt_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               opcode_i,
  input  logic signed [DATA_W-1:0] key_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [IDX_W-1:0]         entry_index_i,
  input  logic signed [DATA_W-1:0] fallback_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               status_o,
  output logic signed [DATA_W-1:0] out_key_o,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic [COUNT_W-1:0]       entry_count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

  // control state
  state_e         state_q, state_d;
  map_mode_e      mode_q;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  scan_q, scan_d;
  logic           pend_q;            // RAM read data valid this cycle
  logic           out_valid_q, out_valid_d;

  // latched transaction
  opcode_e                  op_q;
  logic signed [DATA_W-1:0] key_q, val_q, fb_q;
  logic                     load_item;

  // staged result
  status_e                  res_status_q, res_status_d;
  logic signed [DATA_W-1:0] res_key_q, res_key_d, res_val_q, res_val_d;
  logic                     out_load;

  // output register
  logic [2:0]               status_q;
  logic signed [DATA_W-1:0] okey_q, oval_q;
  logic [COUNT_W-1:0]       ocount_q;

  // RAM ports
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr;
  pair_t         rd_pair, wr_pair;

  // compare of the entry read against the latched pair
  logic ksame, vsame, blocker, more;
  logic [CW+IDX_W-1:0] idx_ext, cnt_ext;
  logic [CW+COUNT_W-1:0] cnt_out_ext;

  assign ksame   = (rd_pair.key == key_q);
  assign vsame   = (rd_pair.value == val_q);
  assign blocker = ksame || ((mode_q == MODE_ONE_TO_ONE) && vsame);
  assign more    = (scan_q < count_q);
  assign idx_ext = {{CW{1'b0}}, entry_index_i};
  assign cnt_ext = {{IDX_W{1'b0}}, count_q};
  assign wr_pair = '{key: key_q, value: val_q};

  cpmt_pair_ram #(
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wr_pair),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_pair)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_d       = scan_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_val_d    = res_val_q;
    rd_en        = 1'b0;
    rd_addr      = scan_q[AW-1:0];
    wr_en        = 1'b0;
    load_item    = 1'b0;
    out_load     = 1'b0;
    in_ready_o   = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          load_item    = 1'b1;
          res_status_d = ST_DONE;
          res_key_d    = '0;
          res_val_d    = '0;
          case (opcode_e'(opcode_i))
            OP_ADD, OP_LOOKUP, OP_CHECK: begin
              scan_d  = '0;
              state_d = S_SCAN;
            end
            OP_READ: begin
              if (idx_ext < cnt_ext) begin
                rd_en   = 1'b1;
                rd_addr = idx_ext[AW-1:0];
                state_d = S_SCAN;
              end else begin
                state_d = S_EMIT;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              state_d = S_EMIT;
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // keep the read port busy; data for entry i arrives in the next cycle
        if ((op_q != OP_READ) && more) begin
          rd_en  = 1'b1;
          scan_d = scan_q + CW'(1);
        end
        if (pend_q) begin
          case (op_q)
            OP_ADD: begin
              if (ksame && vsame) begin
                res_status_d = ST_EXISTS;
                state_d      = S_EMIT;
              end else if (blocker) begin
                res_status_d = ST_CONFLICT;
                state_d      = S_EMIT;
              end
            end
            OP_LOOKUP: begin
              if (ksame) begin
                res_status_d = ST_FOUND;
                res_val_d    = rd_pair.value;
                state_d      = S_EMIT;
              end
            end
            OP_CHECK: begin
              if (!(ksame && vsame) && blocker) begin
                res_status_d = ST_CONFLICT;
                state_d      = S_EMIT;
              end
            end
            OP_READ: begin
              res_status_d = ST_FOUND;
              res_key_d    = rd_pair.key;
              res_val_d    = rd_pair.value;
              state_d      = S_EMIT;
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end else if (!more) begin
          // whole table scanned without a deciding pair
          state_d = S_EMIT;
          case (op_q)
            OP_ADD: begin
              if (count_q >= CAP_CW) begin
                res_status_d = ST_FULL;
              end else begin
                wr_en        = 1'b1;
                count_d      = count_q + CW'(1);
                res_status_d = ST_ADDED;
              end
            end
            OP_LOOKUP: begin
              res_status_d = ST_MISSING;
              res_val_d    = fb_q;
            end
            OP_CHECK: begin
              res_status_d = ST_CLEAN;
            end
            default: begin
              res_status_d = ST_DONE;
            end
          endcase
        end
      end

      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_ONE_TO_ONE;
      count_q     <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      pend_q      <= rd_en;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= map_mode_e'(cfg_wdata_i);
      end
    end
  end

  // payload registers, no reset
  assign cnt_out_ext = {{COUNT_W{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    if (load_item) begin
      op_q  <= opcode_e'(opcode_i);
      key_q <= key_i;
      val_q <= value_i;
      fb_q  <= fallback_i;
    end
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_val_q    <= res_val_d;
    if (out_load) begin
      status_q <= res_status_q;
      okey_q   <= res_key_q;
      oval_q   <= res_val_q;
      ocount_q <= cnt_out_ext[COUNT_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_key_o     = okey_q;
  assign out_value_o   = oval_q;
  assign entry_count_o = ocount_q;

  // checks
  `CPMT_ASSERT_IMP(a_wr_below_cap, clk_i, rst_ni, wr_en, count_q < CAP_CW)
  `CPMT_ASSERT_NXT(a_wr_bumps_count, clk_i, rst_ni, wr_en, count_q == $past(count_q) + CW'(1))
  `CPMT_ASSERT_IMP(a_scan_in_range, clk_i, rst_ni, rd_en && (state_q == S_SCAN), scan_q < count_q)
  `CPMT_ASSERT_IMP(a_accept_no_inflight, clk_i, rst_ni, in_valid_i && in_ready_o, !pend_q)

endmodule

// ===== hw/rtl/cpmt_pair_ram.sv =====
// Pair store: one write port, one read port, registered read data.
// Depends on cpmt_pkg (pair_t, CAPACITY_DEF).
module cpmt_pair_ram import cpmt_pkg::*; #(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  pair_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output pair_t         rdata_o
);

  pair_t mem_q [DEPTH];
  pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/pair_map_checker.sv =====
`timescale 1ns / 100ps
// Checker for the constrained pair map table unit: keeps a mirror of the pair
// table, predicts one result per input transaction and compares in order.
// Depends on cpmt_pkg only.
module pair_map_checker import cpmt_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         opcode_i,
  input  logic [DATA_W-1:0]  key_i,
  input  logic [DATA_W-1:0]  value_i,
  input  logic [IDX_W-1:0]   entry_index_i,
  input  logic [DATA_W-1:0]  fallback_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [2:0]         status_i,
  input  logic [DATA_W-1:0]  out_key_i,
  input  logic [DATA_W-1:0]  out_value_i,
  input  logic [COUNT_W-1:0] entry_count_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   key;
    logic [DATA_W-1:0]   value;
    logic [COUNT_W-1:0]  count;
  } map_result_t;

  logic [DATA_W-1:0] key_mirror   [CAPACITY];
  logic [DATA_W-1:0] value_mirror [CAPACITY];
  int unsigned       pairs_held;
  map_mode_e         mode_now;
  map_result_t       due_results [$];

  // First blocking pair decides; a check passes over exact matches.
  function automatic status_e scan_table(input logic [DATA_W-1:0] k,
                                         input logic [DATA_W-1:0] v,
                                         input bit for_check);
    bit ksame;
    bit vsame;
    for (int i = 0; i < pairs_held; i++) begin
      ksame = key_mirror[i] == k;
      vsame = value_mirror[i] == v;
      if (ksame && vsame) begin
        if (!for_check) return ST_EXISTS;
      end else if (ksame || (mode_now == MODE_ONE_TO_ONE && vsame)) begin
        return ST_CONFLICT;
      end
    end
    return for_check ? ST_CLEAN : ST_ADDED;
  endfunction

  function automatic map_result_t apply_map_op(input logic [2:0] op,
                                               input logic [DATA_W-1:0] k,
                                               input logic [DATA_W-1:0] v,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [DATA_W-1:0] fb);
    map_result_t r;
    bit hit;
    r.status = ST_DONE;
    r.key    = '0;
    r.value  = '0;
    hit      = 1'b0;
    case (op)
      OP_ADD: begin
        r.status = scan_table(k, v, 1'b0);
        if (r.status == ST_ADDED) begin
          if (pairs_held >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            key_mirror[pairs_held]   = k;
            value_mirror[pairs_held] = v;
            pairs_held++;
          end
        end
      end
      OP_LOOKUP: begin
        r.status = ST_MISSING;
        r.value  = fb;
        for (int i = 0; i < pairs_held; i++) begin
          if (!hit && key_mirror[i] == k) begin
            hit      = 1'b1;
            r.status = ST_FOUND;
            r.value  = value_mirror[i];
          end
        end
      end
      OP_CHECK: r.status = scan_table(k, v, 1'b1);
      OP_READ: begin
        if (idx < pairs_held) begin
          r.status = ST_FOUND;
          r.key    = key_mirror[idx];
          r.value  = value_mirror[idx];
        end
      end
      OP_CLEAR: pairs_held = 0;
      default: ;
    endcase
    r.count = COUNT_W'(pairs_held);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    map_result_t want;
    if (!rst_ni) begin
      pairs_held   = 0;
      mode_now     = MODE_ONE_TO_ONE;
      fail_count_o = 0;
      pending_o    = 0;
      due_results.delete();
    end else begin
      if (cfg_we_i) mode_now = map_mode_e'(cfg_wdata_i);
      // results first: a transaction taken at this edge cannot answer at it
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          fail_count_o++;
          $error("result with no transaction outstanding: status %0d count %0d",
                 status_i, entry_count_i);
        end else begin
          want = due_results.pop_front();
          if (status_i !== want.status) begin
            fail_count_o++;
            $error("status: expected %0d actual %0d", want.status, status_i);
          end
          if (out_key_i !== want.key) begin
            fail_count_o++;
            $error("out_key: expected %0d actual %0d",
                   $signed(want.key), $signed(out_key_i));
          end
          if (out_value_i !== want.value) begin
            fail_count_o++;
            $error("out_value: expected %0d actual %0d",
                   $signed(want.value), $signed(out_value_i));
          end
          if (entry_count_i !== want.count) begin
            fail_count_o++;
            $error("entry_count: expected %0d actual %0d", want.count, entry_count_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        due_results.push_back(apply_map_op(opcode_i, key_i, value_i,
                                           entry_index_i, fallback_i));
      end
      pending_o = due_results.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the constrained pair map table unit: clock, reset,
// stimulus, receiver back-pressure and verdict.
// Depends on cpmt_pkg, constrained_pair_map_table_unit and pair_map_checker.
module tb;
  import cpmt_pkg::*;

  localparam int unsigned IDLE_PCT     = 19;   // idle cycles per hundred, each side
  localparam int unsigned STALL_LIMIT  = 4000; // cycles with no transaction at all
  localparam int unsigned HOLD_CYCLES  = 300;  // one long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 240;
  localparam int unsigned POOL_SIZE    = 32;

  // opcodes with no function; the unit must answer done and change nothing
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam logic [DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_ONES = '1;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         opcode_i;
  logic [DATA_W-1:0]  key_i;
  logic [DATA_W-1:0]  value_i;
  logic [IDX_W-1:0]   entry_index_i;
  logic [DATA_W-1:0]  fallback_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [2:0]         status_o;
  logic [DATA_W-1:0]  out_key_o;
  logic [DATA_W-1:0]  out_value_o;
  logic [COUNT_W-1:0] entry_count_o;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned items_sent;
  int unsigned fills;

  // shared between the stimulus and the receiver
  bit calm;      // no idling on either side
  bit hold_req;  // ask the receiver for its long hold-off

  logic [DATA_W-1:0] key_pool   [POOL_SIZE];
  logic [DATA_W-1:0] value_pool [POOL_SIZE];

  constrained_pair_map_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .entry_index_i (entry_index_i),
    .fallback_i    (fallback_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_value_o   (out_value_o),
    .entry_count_o (entry_count_o)
  );

  pair_map_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .entry_index_i (entry_index_i),
    .fallback_i    (fallback_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status_o),
    .out_key_i     (out_key_o),
    .out_value_i   (out_value_o),
    .entry_count_i (entry_count_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count)
  );

  // 4 ns period
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // One transaction on the input channel. Inputs move on the falling edge;
  // the handshake is judged on the rising edge. Valid is only lowered when
  // an idle cycle is taken, never between back-to-back transactions.
  task automatic send_op(input logic [2:0]        op,
                         input logic [DATA_W-1:0] k,
                         input logic [DATA_W-1:0] v,
                         input logic [IDX_W-1:0]  idx,
                         input logic [DATA_W-1:0] fb);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    key_i         <= k;
    value_i       <= v;
    entry_index_i <= idx;
    fallback_i    <= fb;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding result. Each transaction
  // answers exactly once, so an empty queue means the unit is idle; the
  // short pause is margin only.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_count == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_mode(input map_mode_e mode);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Small pools so that keys and values repeat: that is what drives the
  // exists / conflict / found paths. Extremes always sit in the pool.
  task automatic reseed_pools();
    key_pool[0]   = WORD_MIN;
    key_pool[1]   = WORD_MAX;
    key_pool[2]   = '0;
    key_pool[3]   = WORD_ONES;
    value_pool[0] = WORD_MAX;
    value_pool[1] = WORD_MIN;
    value_pool[2] = WORD_ONES;
    value_pool[3] = '0;
    for (int i = 4; i < POOL_SIZE; i++) begin
      key_pool[i]   = (i % 2) ? $urandom : DATA_W'($urandom_range(16)) - 32'd8;
      value_pool[i] = (i % 2) ? DATA_W'($urandom_range(16)) - 32'd8 : $urandom;
    end
  endtask

  // Fill the table to capacity with distinct pairs, then poke the full
  // table: an append is refused, exact and clashing pairs still answer
  // from the scan, and the last slot is readable.
  task automatic fill_table();
    logic [DATA_W-1:0] kbase;
    logic [DATA_W-1:0] vbase;
    kbase = $urandom;
    vbase = $urandom;
    send_op(OP_CLEAR, '0, '0, '0, '0);
    for (int i = 0; i < CAPACITY_DEF; i++) begin
      send_op(OP_ADD, kbase + i, vbase + i, IDX_W'($urandom), $urandom);
    end
    send_op(OP_ADD, kbase + CAPACITY_DEF, vbase + CAPACITY_DEF, '0, '0);
    send_op(OP_ADD, kbase, vbase, '0, '0);
    send_op(OP_ADD, kbase + 3, vbase + 7, '0, '0);
    send_op(OP_READ, '0, '0, '1, '0);
    send_op(OP_READ, '0, '0, '0, '0);
    send_op(OP_LOOKUP, kbase + CAPACITY_DEF - 1, '0, '0, $urandom);
    send_op(OP_CHECK, kbase + 1, vbase + 1, '0, '0);
    fills++;
  endtask

  task automatic random_op();
    int unsigned       pick;
    logic [2:0]        op;
    logic [DATA_W-1:0] k;
    logic [DATA_W-1:0] v;
    logic [IDX_W-1:0]  idx;
    pick = $urandom_range(99);
    k    = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
    v    = ($urandom_range(99) < 85) ? value_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
    // bias reads towards the low half, where entries usually live
    idx  = $urandom_range(1) ? IDX_W'($urandom_range(31)) : IDX_W'($urandom);
    if (pick < 40) begin
      op = OP_ADD;
    end else if (pick < 60) begin
      op = OP_LOOKUP;
    end else if (pick < 72) begin
      op = OP_CHECK;
    end else if (pick < 90) begin
      op = OP_READ;
    end else if (pick < 93) begin
      op = OP_CLEAR;
    end else if (pick < 96) begin
      case ($urandom_range(2))
        0:       op = OP_SPARE_5;
        1:       op = OP_SPARE_6;
        default: op = OP_SPARE_7;
      endcase
    end else begin
      // fresh pair, almost surely distinct
      op = OP_ADD;
      k  = $urandom;
      v  = $urandom;
    end
    send_op(op, k, v, idx, $urandom);
  endtask

  // Receiver: random ready, except in the calm phase and for one long
  // hold-off while the sender keeps offering, so the unit fills its result
  // register, takes one more transaction and then stalls its input.
  initial begin : receiver
    bit hold_served;
    hold_served = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: any run of cycles with no transaction on either channel that
  // reaches the limit is a hang.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL constrained_pair_map_table_unit");
    $finish;
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = MODE_ONE_TO_ONE;
    in_valid_i    = 1'b0;
    opcode_i      = OP_ADD;
    key_i         = '0;
    value_i       = '0;
    entry_index_i = '0;
    fallback_i    = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    items_sent    = 0;
    fills         = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed corner cases, one-to-one mode straight out of reset
    send_op(OP_SPARE_5, WORD_MAX, WORD_MIN, '1, WORD_ONES); // unused op, empty table
    send_op(OP_LOOKUP, WORD_MIN, '0, '0, WORD_MIN);         // miss returns fallback
    send_op(OP_READ, '0, '0, '0, '0);                       // bad index on empty table
    send_op(OP_CHECK, '0, '0, '0, '0);                      // nothing to clash with
    send_op(OP_ADD, WORD_MAX, WORD_MIN, '0, '0);
    send_op(OP_ADD, WORD_MAX, WORD_MIN, '0, '0);            // exact pair: exists
    send_op(OP_ADD, WORD_MAX, 32'd5, '0, '0);               // key clash
    send_op(OP_ADD, 32'd1, WORD_MIN, '0, '0);               // value clash, one-to-one
    send_op(OP_ADD, WORD_MIN, WORD_MAX, '0, '0);
    send_op(OP_ADD, '0, '0, '0, '0);
    send_op(OP_ADD, WORD_ONES, WORD_ONES, '0, '0);
    send_op(OP_LOOKUP, WORD_MAX, '0, '0, WORD_ONES);        // hit on first entry
    send_op(OP_LOOKUP, 32'd12345, '0, '0, WORD_MAX);
    send_op(OP_CHECK, WORD_MAX, WORD_MIN, '0, '0);          // exact match passed over
    send_op(OP_CHECK, '0, 32'd9, '0, '0);                   // key clash
    send_op(OP_CHECK, 32'd9, WORD_ONES, '0, '0);            // value clash
    send_op(OP_READ, '0, '0, 6'd3, '0);                     // last stored entry
    send_op(OP_READ, '0, '0, 6'd4, '0);                     // one past the end
    send_op(OP_READ, '0, '0, '1, '0);
    send_op(OP_SPARE_6, WORD_ONES, WORD_ONES, '1, WORD_ONES);
    send_op(OP_SPARE_7, WORD_ONES, WORD_ONES, '1, WORD_ONES);
    send_op(OP_CLEAR, WORD_ONES, WORD_ONES, '1, WORD_ONES);
    send_op(OP_LOOKUP, WORD_ONES, '0, '0, '0);              // gone after clear

    // many-to-one: a shared value is fine, a shared key is not
    write_mode(MODE_MANY_TO_ONE);
    send_op(OP_ADD, 32'd5, 32'd7, '0, '0);
    send_op(OP_ADD, 32'd6, 32'd7, '0, '0);
    send_op(OP_CHECK, 32'd8, 32'd7, '0, '0);
    send_op(OP_ADD, 32'd5, 32'd8, '0, '0);

    // Random phases, alternating the mode; two phases start from a full
    // table, one carries the receiver hold-off, one runs without idling.
    for (int p = 0; p < PHASES; p++) begin
      write_mode((p % 2 == 0) ? MODE_ONE_TO_ONE : MODE_MANY_TO_ONE);
      reseed_pools();
      calm = (p == 4);
      if (p == 2 || p == 5) fill_table();
      if (p == 3) hold_req = 1'b1;
      repeat (PHASE_ITEMS) random_op();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d transactions: directed corner cases, then %0d random phases",
             items_sent, PHASES);
    $display("in both map modes, %0d fills to capacity and a %0d-cycle receiver hold-off.",
             fills, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("PASS constrained_pair_map_table_unit");
    end else begin
      $display("FAIL constrained_pair_map_table_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cpmt_pkg.sv
hw/rtl/cpmt_pair_ram.sv
hw/rtl/constrained_pair_map_table_unit.sv
sim/pair_map_checker.sv
sim/tb.sv
